// ===== rtl/c8080alu_pkg.sv =====
// Shared types and codes for the 8080-style ALU block.
// Holds the operation codes, writeback codes and the word structs used by
// the top level and the ALU datapath.
package c8080alu_pkg;

    localparam int KindWidth = 5;
    localparam int WbWidth   = 2;

    typedef logic [KindWidth-1:0] kind_t;
    typedef logic [WbWidth-1:0]   wb_t;

    // Operation codes
    localparam kind_t KIND_ADD = 5'd0;
    localparam kind_t KIND_ADC = 5'd1;
    localparam kind_t KIND_SUB = 5'd2;
    localparam kind_t KIND_SBB = 5'd3;
    localparam kind_t KIND_ANA = 5'd4;
    localparam kind_t KIND_ORA = 5'd5;
    localparam kind_t KIND_XRA = 5'd6;
    localparam kind_t KIND_CMP = 5'd7;
    localparam kind_t KIND_INR = 5'd8;
    localparam kind_t KIND_DCR = 5'd9;
    localparam kind_t KIND_DAA = 5'd10;
    localparam kind_t KIND_RLC = 5'd11;
    localparam kind_t KIND_RRC = 5'd12;
    localparam kind_t KIND_RAL = 5'd13;
    localparam kind_t KIND_RAR = 5'd14;
    localparam kind_t KIND_CMA = 5'd15;
    localparam kind_t KIND_CMC = 5'd16;
    localparam kind_t KIND_STC = 5'd17;
    localparam kind_t KIND_INX = 5'd18;
    localparam kind_t KIND_DCX = 5'd19;
    localparam kind_t KIND_DAD = 5'd20;

    // Writeback codes
    localparam wb_t WB_NONE = 2'd0;
    localparam wb_t WB_BYTE = 2'd1;
    localparam wb_t WB_PAIR = 2'd2;

    // DAA constants
    localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
    localparam logic [3:0] BCD_MAX      = 4'd9;

    typedef struct packed {
        logic sign;
        logic zero;
        logic aux;
        logic parity;
        logic carry;
    } flags_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  acc_value;
        logic [7:0]  operand_value;
        logic [15:0] pair_first;
        logic [15:0] pair_second;
        flags_t      flags;
    } alu_in_t;

    typedef struct packed {
        logic [7:0]  byte_result;
        logic [15:0] pair_result;
        wb_t         writeback;
        flags_t      flags;
    } alu_out_t;

endpackage

// ===== rtl/cpu8080_alu_flags.sv =====
// Top level of the 8080-style ALU: stream ports, input and result registers.
// Depends on c8080alu_pkg and c8080alu_core.
//
//  port group | dir | tdata fields (low bit up)                      | tuser
//  s_*        | in  | acc_value, operand_value, pair_first,          | kind
//             |     | pair_second, sign/zero/aux/parity/carry_in     |
//  m_*        | out | byte_result, pair_result,                      | writeback
//             |     | sign/zero/aux/parity/carry_out                 |
//
// One word per cycle while m_tready allows: the input register feeds the ALU
// logic, whose output lands in the result register.
// aresetn clears both valid flags; payload registers are not reset.
// A stall on m_tready holds the result register; the input register keeps
// taking words as long as the result register can drain or is empty.
module cpu8080_alu_flags
    import c8080alu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // acc_value[7:0], operand_value[15:8], pair_first[31:16], pair_second[47:32],
    // sign_in[48], zero_in[49], aux_in[50], parity_in[51], carry_in[52], zero pad
    input  logic [55:0] s_tdata,
    // kind[4:0]
    input  logic [4:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_result[7:0], pair_result[23:8], sign_out[24], zero_out[25],
    // aux_out[26], parity_out[27], carry_out[28], zero pad
    output logic [31:0] m_tdata,
    // writeback[1:0]
    output logic [1:0]  m_tuser
);

    logic     in_valid_reg;
    logic     in_valid_next;
    alu_in_t  in_word_reg;
    alu_in_t  in_word_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    alu_out_t out_word_reg;
    alu_out_t alu_result;
    logic     out_load;
    logic     in_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_comb begin
        in_word_next.kind          = s_tuser;
        in_word_next.acc_value     = s_tdata[7:0];
        in_word_next.operand_value = s_tdata[15:8];
        in_word_next.pair_first    = s_tdata[31:16];
        in_word_next.pair_second   = s_tdata[47:32];
        in_word_next.flags.sign    = s_tdata[48];
        in_word_next.flags.zero    = s_tdata[49];
        in_word_next.flags.aux     = s_tdata[50];
        in_word_next.flags.parity  = s_tdata[51];
        in_word_next.flags.carry   = s_tdata[52];
    end

    // advance the input stage when it drains or a new word arrives
    assign in_valid_next  = in_load || (in_valid_reg && !out_load);
    // hold the result until taken
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_word_reg <= in_word_next;
        end
        if (out_load) begin
            out_word_reg <= alu_result;
        end
    end

    c8080alu_core u_core (
        .op_in  (in_word_reg),
        .op_out (alu_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_word_reg.flags.carry,
                       out_word_reg.flags.parity,
                       out_word_reg.flags.aux,
                       out_word_reg.flags.zero,
                       out_word_reg.flags.sign,
                       out_word_reg.pair_result,
                       out_word_reg.byte_result};
    assign m_tuser  = out_word_reg.writeback;

endmodule

// ===== rtl/c8080alu_core.sv =====
// Combinational datapath of the 8080-style ALU: one operation per word.
// Depends on c8080alu_pkg for codes and the input and result structs.
module c8080alu_core
    import c8080alu_pkg::*;
(
    input  alu_in_t  op_in,
    output alu_out_t op_out
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  nb;
    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic        lo_gt9;
    logic        hi_adj;
    logic [7:0]  corr;
    logic [16:0] dad_sum;
    logic [7:0]  res;
    logic [15:0] pres;
    wb_t         wb;
    logic        szp;
    flags_t      fin;
    flags_t      fout;

    assign a   = op_in.acc_value;
    assign b   = op_in.operand_value;
    assign nb  = ~op_in.operand_value;
    assign fin = op_in.flags;

    // DAA correction terms
    assign lo_gt9 = (a[3:0] > BCD_MAX);
    assign hi_adj = (a[7:4] > BCD_MAX) || ((a[7:4] >= BCD_MAX) && lo_gt9) || fin.carry;
    assign corr   = ((lo_gt9 || fin.aux) ? DAA_LOW_ADJ : 8'h00)
                  | (hi_adj ? DAA_HIGH_ADJ : 8'h00);

    assign dad_sum = {1'b0, op_in.pair_first} + {1'b0, op_in.pair_second};

    always_comb begin
        res  = 8'h00;
        pres = 16'h0000;
        wb   = WB_NONE;
        szp  = 1'b0;
        fout = fin;
        cin  = 1'b0;
        sum9 = 9'h000;
        nib5 = 5'h00;
        unique case (op_in.kind)
            KIND_ADD, KIND_ADC: begin
                cin        = (op_in.kind == KIND_ADC) ? fin.carry : 1'b0;
                sum9       = {1'b0, a} + {1'b0, b} + {8'h00, cin};
                nib5       = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
                fout.aux   = nib5[4];
                fout.carry = sum9[8];
                res        = sum9[7:0];
                wb         = WB_BYTE;
                szp        = 1'b1;
            end
            KIND_SUB, KIND_SBB, KIND_CMP: begin
                // subtract as a + ~b + !borrow; carry flag is the borrow
                cin        = ~((op_in.kind == KIND_SBB) ? fin.carry : 1'b0);
                sum9       = {1'b0, a} + {1'b0, nb} + {8'h00, cin};
                nib5       = {1'b0, a[3:0]} + {1'b0, nb[3:0]} + {4'h0, cin};
                fout.aux   = nib5[4];
                fout.carry = ~sum9[8];
                res        = sum9[7:0];
                wb         = (op_in.kind == KIND_CMP) ? WB_NONE : WB_BYTE;
                szp        = 1'b1;
            end
            KIND_ANA, KIND_ORA, KIND_XRA: begin
                res        = (op_in.kind == KIND_ANA) ? (a & b)
                           : (op_in.kind == KIND_ORA) ? (a | b) : (a ^ b);
                fout.aux   = 1'b0;
                fout.carry = 1'b0;
                wb         = WB_BYTE;
                szp        = 1'b1;
            end
            KIND_INR: begin
                fout.aux = (a[3:0] == 4'hF);
                res      = a + 8'h01;
                wb       = WB_BYTE;
                szp      = 1'b1;
            end
            KIND_DCR: begin
                fout.aux = (a[3:0] != 4'h0);
                res      = a - 8'h01;
                wb       = WB_BYTE;
                szp      = 1'b1;
            end
            KIND_DAA: begin
                nib5     = {1'b0, a[3:0]} + {1'b0, corr[3:0]};
                fout.aux = nib5[4];
                if (hi_adj) begin
                    fout.carry = 1'b1;
                end
                res = a + corr;
                wb  = WB_BYTE;
                szp = 1'b1;
            end
            KIND_RLC: begin
                res        = {a[6:0], a[7]};
                fout.carry = a[7];
                wb         = WB_BYTE;
            end
            KIND_RRC: begin
                res        = {a[0], a[7:1]};
                fout.carry = a[0];
                wb         = WB_BYTE;
            end
            KIND_RAL: begin
                res        = {a[6:0], fin.carry};
                fout.carry = a[7];
                wb         = WB_BYTE;
            end
            KIND_RAR: begin
                res        = {fin.carry, a[7:1]};
                fout.carry = a[0];
                wb         = WB_BYTE;
            end
            KIND_CMA: begin
                res = ~a;
                wb  = WB_BYTE;
            end
            KIND_CMC: begin
                fout.carry = ~fin.carry;
            end
            KIND_STC: begin
                fout.carry = 1'b1;
            end
            KIND_INX: begin
                pres = op_in.pair_first + 16'h0001;
                wb   = WB_PAIR;
            end
            KIND_DCX: begin
                pres = op_in.pair_first - 16'h0001;
                wb   = WB_PAIR;
            end
            KIND_DAD: begin
                pres       = dad_sum[15:0];
                fout.carry = dad_sum[16];
                wb         = WB_PAIR;
            end
            default: begin
                // unused codes: write nothing, keep all flags
                wb = WB_NONE;
            end
        endcase
        if (szp) begin
            fout.sign   = res[7];
            fout.zero   = (res == 8'h00);
            fout.parity = ~^res;
        end
    end

    assign op_out.byte_result = res;
    assign op_out.pair_result = pres;
    assign op_out.writeback   = wb;
    assign op_out.flags       = fout;

endmodule

// ===== tb/sv/cpu8080_alu_flags_test.sv =====
// Self-checking testbench for cpu8080_alu_flags: directed and random ALU words,
// with results predicted in a scoreboard class and checked in order.
// Depends on c8080alu_pkg and the cpu8080_alu_flags RTL.
`timescale 1ns / 100ps

module cpu8080_alu_flags_test;
    import c8080alu_pkg::*;

    localparam int KIND_TOP       = 2**KindWidth - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int RANDOM_WORDS   = 1950;

    class alu_scoreboard;
        alu_out_t expected_results[$];
        int       errors;

        // Compute the result word for one ALU input word.
        function alu_out_t alu_step(alu_in_t w);
            alu_out_t    r;
            logic [8:0]  sum9;
            logic [4:0]  nib;
            logic [16:0] sum17;
            logic [7:0]  a, b, nb, corr;
            logic        cin, szp;
            r = '0;
            r.flags = w.flags;
            r.writeback = WB_NONE;
            a = w.acc_value;
            b = w.operand_value;
            szp = 1'b0;
            case (w.kind)
                KIND_ADD, KIND_ADC: begin
                    cin = (w.kind == KIND_ADC) & w.flags.carry;
                    sum9 = {1'b0, a} + {1'b0, b} + {8'h00, cin};
                    nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
                    r.flags.aux = nib[4];
                    r.flags.carry = sum9[8];
                    r.byte_result = sum9[7:0];
                    r.writeback = WB_BYTE;
                    szp = 1'b1;
                end
                KIND_SUB, KIND_SBB, KIND_CMP: begin
                    // a + ~b + !borrow_in; carry out of that sum is the inverted borrow
                    cin = (w.kind == KIND_SBB) & w.flags.carry;
                    nb = ~b;
                    sum9 = {1'b0, a} + {1'b0, nb} + {8'h00, !cin};
                    nib = {1'b0, a[3:0]} + {1'b0, nb[3:0]} + {4'h0, !cin};
                    r.flags.aux = nib[4];
                    r.flags.carry = ~sum9[8];
                    r.byte_result = sum9[7:0];
                    r.writeback = (w.kind == KIND_CMP) ? WB_NONE : WB_BYTE;
                    szp = 1'b1;
                end
                KIND_ANA, KIND_ORA, KIND_XRA: begin
                    r.byte_result = (w.kind == KIND_ANA) ? (a & b) :
                                    (w.kind == KIND_ORA) ? (a | b) : (a ^ b);
                    r.flags.aux = 1'b0;
                    r.flags.carry = 1'b0;
                    r.writeback = WB_BYTE;
                    szp = 1'b1;
                end
                KIND_INR: begin
                    r.flags.aux = (a[3:0] == 4'hF);
                    r.byte_result = a + 8'd1;
                    r.writeback = WB_BYTE;
                    szp = 1'b1;
                end
                KIND_DCR: begin
                    r.flags.aux = (a[3:0] != 4'h0);
                    r.byte_result = a - 8'd1;
                    r.writeback = WB_BYTE;
                    szp = 1'b1;
                end
                KIND_DAA: begin
                    corr = '0;
                    if (a[3:0] > BCD_MAX || w.flags.aux) begin
                        corr |= DAA_LOW_ADJ;
                    end
                    if (a[7:4] > BCD_MAX || (a[7:4] >= BCD_MAX && a[3:0] > BCD_MAX) ||
                        w.flags.carry) begin
                        corr |= DAA_HIGH_ADJ;
                        r.flags.carry = 1'b1;
                    end
                    nib = {1'b0, a[3:0]} + {1'b0, corr[3:0]};
                    r.flags.aux = nib[4];
                    r.byte_result = a + corr;
                    r.writeback = WB_BYTE;
                    szp = 1'b1;
                end
                KIND_RLC: begin
                    r.byte_result = {a[6:0], a[7]};
                    r.flags.carry = a[7];
                    r.writeback = WB_BYTE;
                end
                KIND_RRC: begin
                    r.byte_result = {a[0], a[7:1]};
                    r.flags.carry = a[0];
                    r.writeback = WB_BYTE;
                end
                KIND_RAL: begin
                    r.byte_result = {a[6:0], w.flags.carry};
                    r.flags.carry = a[7];
                    r.writeback = WB_BYTE;
                end
                KIND_RAR: begin
                    r.byte_result = {w.flags.carry, a[7:1]};
                    r.flags.carry = a[0];
                    r.writeback = WB_BYTE;
                end
                KIND_CMA: begin
                    r.byte_result = ~a;
                    r.writeback = WB_BYTE;
                end
                KIND_CMC: r.flags.carry = ~w.flags.carry;
                KIND_STC: r.flags.carry = 1'b1;
                KIND_INX: begin
                    r.pair_result = w.pair_first + 16'd1;
                    r.writeback = WB_PAIR;
                end
                KIND_DCX: begin
                    r.pair_result = w.pair_first - 16'd1;
                    r.writeback = WB_PAIR;
                end
                KIND_DAD: begin
                    sum17 = {1'b0, w.pair_first} + {1'b0, w.pair_second};
                    r.pair_result = sum17[15:0];
                    r.flags.carry = sum17[16];
                    r.writeback = WB_PAIR;
                end
                default: ;
            endcase
            if (szp) begin
                r.flags.sign = r.byte_result[7];
                r.flags.zero = (r.byte_result == 8'h00);
                r.flags.parity = ~^r.byte_result;
            end
            return r;
        endfunction

        function void note_input(alu_in_t w);
            expected_results.push_back(alu_step(w));
        endfunction

        function void check_result(alu_out_t got);
            alu_out_t want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("ALU error: unexpected result byte %h pair %h wb %0d flags %b",
                             got.byte_result, got.pair_result, got.writeback, got.flags);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.byte_result != want.byte_result || got.pair_result != want.pair_result ||
                got.writeback != want.writeback || got.flags.sign != want.flags.sign ||
                got.flags.zero != want.flags.zero || got.flags.aux != want.flags.aux ||
                got.flags.parity != want.flags.parity ||
                got.flags.carry != want.flags.carry) begin
                errors++;
                if (errors <= 10) begin
                    $display("ALU error: byte %h/%h pair %h/%h wb %0d/%0d szapc %b/%b (exp/got)",
                             want.byte_result, got.byte_result, want.pair_result,
                             got.pair_result, want.writeback, got.writeback,
                             want.flags, got.flags);
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [4:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    alu_scoreboard sb = new();
    int            burst_left = 0;
    int            idle_cycles = 0;

    cpu8080_alu_flags i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic alu_in_t make_word(kind_t k, logic [7:0] a, logic [7:0] b,
                                          logic [15:0] p1, logic [15:0] p2,
                                          logic [4:0] szapc);
        alu_in_t w;
        w.kind = k;
        w.acc_value = a;
        w.operand_value = b;
        w.pair_first = p1;
        w.pair_second = p2;
        w.flags = szapc;
        return w;
    endfunction

    // Bias toward the corners that matter for carries and decimal adjust.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return {4'($urandom_range(8, 10)), 4'($urandom_range(8, 15))};
            3: return {4'($urandom), 4'hF};
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one word and hold it until accepted; gaps fall between bursts.
    task automatic send_word(alu_in_t w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.kind;
        s_tdata  <= {3'b000, w.flags.carry, w.flags.parity, w.flags.aux, w.flags.zero,
                     w.flags.sign, w.pair_second, w.pair_first, w.operand_value,
                     w.acc_value};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(w);
        burst_left--;
    endtask

    // Receiver: open briefly, hold off long enough to back up the pipe, then
    // switch between stall patterns in segments.
    initial begin
        int seg;
        int mode;
        @(posedge aclk iff aresetn);
        repeat (40) begin
            @(posedge aclk);
            m_tready <= 1'b1;
        end
        repeat (200) begin
            @(posedge aclk);
            m_tready <= 1'b0;
        end
        forever begin
            seg = $urandom_range(10, 60);
            mode = $urandom_range(0, 2);
            repeat (seg) begin
                @(posedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        alu_out_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.byte_result  = m_tdata[7:0];
            got.pair_result  = m_tdata[23:8];
            got.writeback    = m_tuser;
            got.flags.sign   = m_tdata[24];
            got.flags.zero   = m_tdata[25];
            got.flags.aux    = m_tdata[26];
            got.flags.parity = m_tdata[27];
            got.flags.carry  = m_tdata[28];
            sb.check_result(got);
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("cpu8080_alu_flags: mismatch");
            $finish;
        end
    end

    initial begin
        alu_in_t w;
        int      drain;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners: wraps, borrows, flag clears and pass-through
        send_word(make_word(KIND_ADD, 8'hFF, 8'h01, 16'h0000, 16'h0000, 5'b00000));
        send_word(make_word(KIND_ADC, 8'hFF, 8'h00, 16'h0000, 16'h0000, 5'b00001));
        send_word(make_word(KIND_ADC, 8'h7F, 8'h80, 16'h0000, 16'h0000, 5'b00001));
        send_word(make_word(KIND_SUB, 8'h00, 8'h01, 16'h0000, 16'h0000, 5'b00000));
        send_word(make_word(KIND_SBB, 8'h10, 8'h0F, 16'h0000, 16'h0000, 5'b00001));
        send_word(make_word(KIND_CMP, 8'h55, 8'h55, 16'h0000, 16'h0000, 5'b10001));
        send_word(make_word(KIND_ANA, 8'hF0, 8'h0F, 16'h0000, 16'h0000, 5'b00101));
        send_word(make_word(KIND_ORA, 8'h80, 8'h01, 16'h0000, 16'h0000, 5'b01111));
        send_word(make_word(KIND_XRA, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 5'b11111));
        send_word(make_word(KIND_INR, 8'hFF, 8'h00, 16'h0000, 16'h0000, 5'b00001));
        send_word(make_word(KIND_INR, 8'h0F, 8'h00, 16'h0000, 16'h0000, 5'b01000));
        send_word(make_word(KIND_DCR, 8'h00, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        send_word(make_word(KIND_DCR, 8'h10, 8'h00, 16'h0000, 16'h0000, 5'b00101));
        send_word(make_word(KIND_DAA, 8'h9A, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        send_word(make_word(KIND_DAA, 8'h99, 8'h00, 16'h0000, 16'h0000, 5'b00001));
        send_word(make_word(KIND_DAA, 8'h0F, 8'h00, 16'h0000, 16'h0000, 5'b00100));
        send_word(make_word(KIND_RLC, 8'h80, 8'h00, 16'h0000, 16'h0000, 5'b11110));
        send_word(make_word(KIND_RRC, 8'h01, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        send_word(make_word(KIND_RAL, 8'h80, 8'h00, 16'h0000, 16'h0000, 5'b00000));
        send_word(make_word(KIND_RAR, 8'h01, 8'h00, 16'h0000, 16'h0000, 5'b00001));
        send_word(make_word(KIND_CMA, 8'h5A, 8'h00, 16'h0000, 16'h0000, 5'b11111));
        send_word(make_word(KIND_CMC, 8'h00, 8'h00, 16'h0000, 16'h0000, 5'b11111));
        send_word(make_word(KIND_STC, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 5'b00000));
        send_word(make_word(KIND_INX, 8'h00, 8'h00, 16'hFFFF, 16'h0000, 5'b10101));
        send_word(make_word(KIND_DCX, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 5'b01010));
        send_word(make_word(KIND_DAD, 8'h00, 8'h00, 16'hFFFF, 16'h0001, 5'b11110));
        send_word(make_word(kind_t'(KIND_TOP), 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                            5'b11111));

        repeat (RANDOM_WORDS) begin
            if ($urandom_range(0, 19) == 0) begin
                w.kind = kind_t'($urandom_range(KIND_DAD + 1, KIND_TOP));
            end else begin
                w.kind = kind_t'($urandom_range(KIND_ADD, KIND_DAD));
            end
            w.acc_value = pick_byte();
            w.operand_value = pick_byte();
            w.pair_first = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
            w.pair_second = ($urandom_range(0, 7) == 0) ? 16'h0001 : 16'($urandom);
            w.flags = 5'($urandom);
            send_word(w);
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (sb.expected_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (4) @(posedge aclk);
        if (sb.expected_results.size() != 0) begin
            $display("ALU error: %0d results never arrived", sb.expected_results.size());
        end
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("cpu8080_alu_flags: match");
        end else begin
            $display("cpu8080_alu_flags: mismatch");
        end
        $finish;
    end

endmodule
